// ===== hdl/tsrl_pkg.sv =====
// Shared widths and register indexes for the timestamped slew-rate limiter.
`timescale 1ns / 1ps

package tsrl_pkg;

    localparam int TIME_W      = 32;
    localparam int DATA_W      = 32;
    localparam int CFG_INDEX_W = 1;

    typedef logic        [TIME_W-1:0] time_word_t;
    typedef logic signed [DATA_W-1:0] data_word_t;
    typedef logic [CFG_INDEX_W-1:0]   cfg_index_t;

    localparam cfg_index_t CFG_RISING_LIMIT  = 1'd0;
    localparam cfg_index_t CFG_FALLING_LIMIT = 1'd1;

endpackage

// ===== hdl/timestamped_slew_rate_limiter.sv =====
// Top level of the timestamped slew-rate limiter, signed Q16.16.
`timescale 1ns / 1ps

// Usage
// - Input channel: in_valid / in_stall carry one word of sample_time and
//   sample_value. A word is taken at a rising edge with in_valid high and
//   in_stall low.
// - Output channel: out_valid / out_stall carry one limited_value per input
//   word, in order. The word is taken at a rising edge with out_valid high
//   and out_stall low.
// - Configuration: cfg_wr_en writes cfg_data into rising_limit (index 0) or
//   falling_limit (index 1). Write only while no word is in flight.
// - Path: a word passes through the input register and then the result
//   register before it shows on the output.
// - Throughput: one word per cycle while the output is not stalled. The whole
//   evaluation (anchor commit, two 32x33 signed products, compares, clamp and
//   saturating add) sits between the input register and the result register,
//   so state is ready for the next word in the cycle after.
// - Stall: when the result register is full and stalled, the input register
//   holds its word and in_stall goes high; otherwise input keeps flowing.
// - Reset: clears limits, anchor and last evaluation to zero and empties
//   both registers.
module timestamped_slew_rate_limiter
    import tsrl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  cfg_index_t cfg_index,
    input  data_word_t cfg_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  time_word_t sample_time,
    input  data_word_t sample_value,
    output logic       out_valid,
    input  logic       out_stall,
    output data_word_t limited_value
);

    // Clamp the projected step to +/- 2^40, add the anchor and saturate.
    function automatic data_word_t project(input logic signed [64:0] prod,
                                           input data_word_t base);
        logic signed [64:0] clamped;
        logic signed [42:0] sum;
        begin
            clamped = prod;
            if (prod > 65'sh100_0000_0000)
            begin
                clamped = 65'sh100_0000_0000;
            end
            if (prod < -65'sh100_0000_0000)
            begin
                clamped = -65'sh100_0000_0000;
            end
            sum = {clamped[41], clamped[41:0]}
                + {{(43-DATA_W){base[DATA_W-1]}}, base};
            if (sum > 43'sh0_7FFF_FFFF)
            begin
                project = {1'b0, {(DATA_W-1){1'b1}}};
            end
            else if (sum < -43'sh0_8000_0000)
            begin
                project = {1'b1, {(DATA_W-1){1'b0}}};
            end
            else
            begin
                project = sum[DATA_W-1:0];
            end
        end
    endfunction

    // Configuration registers
    data_word_t rising_limit_reg;
    data_word_t falling_limit_reg;

    // Input register
    logic       s1_valid_reg;
    time_word_t s1_time_reg;
    data_word_t s1_value_reg;

    // Limiter state
    time_word_t anchor_time_reg;
    data_word_t anchor_value_reg;
    time_word_t last_time_reg;
    data_word_t last_value_reg;
    time_word_t anchor_time_next;
    data_word_t anchor_value_next;

    // Result register
    logic       out_valid_reg;
    data_word_t limited_value_reg;
    data_word_t limited_value_next;

    logic               in_acc;
    logic               s1_adv;
    logic               take_anchor;
    logic signed [32:0] dt;
    logic signed [32:0] diff;
    logic signed [64:0] diff_ext;
    logic signed [64:0] prod_rise;
    logic signed [64:0] prod_fall;
    logic               dt_pos;
    logic               over_rise;
    logic               under_fall;

    // Move the input word on whenever the result register is free or draining.
    assign s1_adv   = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && out_valid_reg && out_stall;
    assign in_acc   = in_valid && !in_stall;

    always_comb
    begin
        // Commit the last evaluation as anchor when time moves past it.
        take_anchor       = s1_time_reg > last_time_reg;
        anchor_time_next  = take_anchor ? last_time_reg : anchor_time_reg;
        anchor_value_next = take_anchor ? last_value_reg : anchor_value_reg;

        dt   = $signed({1'b0, s1_time_reg}) - $signed({1'b0, anchor_time_next});
        diff = {s1_value_reg[DATA_W-1], s1_value_reg}
             - {anchor_value_next[DATA_W-1], anchor_value_next};
        diff_ext = {{32{diff[32]}}, diff};

        // Cross-multiplied rate test; the same products feed the projection.
        prod_rise = $signed({{33{rising_limit_reg[DATA_W-1]}}, rising_limit_reg})
                  * $signed({{32{dt[32]}}, dt});
        prod_fall = $signed({{33{falling_limit_reg[DATA_W-1]}}, falling_limit_reg})
                  * $signed({{32{dt[32]}}, dt});

        dt_pos = !dt[32] && (dt != 33'sd0);
        if (dt_pos)
        begin
            over_rise  = diff_ext > prod_rise;
            under_fall = diff_ext < prod_fall;
        end
        else
        begin
            // Time at or before the anchor: rate counts as zero.
            over_rise  = rising_limit_reg[DATA_W-1];
            under_fall = !falling_limit_reg[DATA_W-1] && (falling_limit_reg != '0);
        end

        // Rising test wins when both fire.
        if (over_rise)
        begin
            limited_value_next = project(prod_rise, anchor_value_next);
        end
        else if (under_fall)
        begin
            limited_value_next = project(prod_fall, anchor_value_next);
        end
        else
        begin
            limited_value_next = s1_value_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rising_limit_reg  <= '0;
            falling_limit_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_RISING_LIMIT:  rising_limit_reg  <= cfg_data;
                CFG_FALLING_LIMIT: falling_limit_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            anchor_time_reg  <= '0;
            anchor_value_reg <= '0;
            last_time_reg    <= '0;
            last_value_reg   <= '0;
        end
        else
        begin
            if (in_acc)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_adv)
            begin
                out_valid_reg    <= 1'b1;
                anchor_time_reg  <= anchor_time_next;
                anchor_value_reg <= anchor_value_next;
                last_time_reg    <= s1_time_reg;
                last_value_reg   <= limited_value_next;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: load only, no reset.
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_time_reg  <= sample_time;
            s1_value_reg <= sample_value;
        end
        if (s1_adv)
        begin
            limited_value_reg <= limited_value_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign limited_value = limited_value_reg;

endmodule

// ===== hdl/tsrl_checker.sv =====
// Port-level checker for the timestamped slew-rate limiter, with its bind.
`timescale 1ns / 1ps

module tsrl_checker
    import tsrl_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input data_word_t limited_value
);

    logic       in_acc;
    logic       out_acc;
    logic [1:0] inflight_reg;

    assign in_acc  = in_valid && !in_stall;
    assign out_acc = out_valid && !out_stall;

    // Count words taken but not yet delivered.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= 2'd0;
        end
        else if (in_acc && !out_acc)
        begin
            inflight_reg <= inflight_reg + 2'd1;
        end
        else if (out_acc && !in_acc)
        begin
            inflight_reg <= inflight_reg - 2'd1;
        end
    end

    a_hold_word: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(limited_value))
        else $error("stalled output word dropped or changed");

    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> inflight_reg != 2'd0)
        else $error("output word with no input word in flight");

    a_idle_open: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg == 2'd0 |-> !in_stall)
        else $error("input stalled while empty");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && inflight_reg == 2'd0 |=> ##1 out_valid)
        else $error("word not delivered two cycles after entry");

endmodule

bind timestamped_slew_rate_limiter tsrl_checker u_tsrl_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .limited_value (limited_value)
);

// ===== verif/timestamped_slew_rate_limiter_tb.sv =====
// Self-checking testbench for the timestamped slew-rate limiter.
`timescale 1ns / 1ps

module timestamped_slew_rate_limiter_tb;
    import tsrl_pkg::*;

    localparam int     CYCLE_LIMIT = 400000;
    localparam int     IDLE_TAIL   = 4;      // result register plus margin
    localparam int     HOLD_LEN    = 300;    // long receiver hold-off
    localparam int     PHASES      = 10;
    localparam int     PHASE_WORDS = 115;
    localparam longint PROD_CAP    = 64'sd1 << 40;
    localparam longint DATA_MAX    = 64'sd2147483647;
    localparam longint DATA_MIN    = -64'sd2147483648;

    // Directed rows either rewrite both limits (block idle) or send one word.
    typedef enum logic {ROW_LIMITS, ROW_SAMPLE} row_kind_t;

    typedef struct packed {
        row_kind_t  kind;
        time_word_t t;
        data_word_t v;
        data_word_t rise;
        data_word_t fall;
        logic       fixed;   // expected value typed in below
        data_word_t lit;
    } stim_row_t;

    localparam int DIR_ROWS = 22;

    // Fixed expectations only where obvious: limits zero after reset give
    // pass-through at the anchor time, and hold the anchor once time moves.
    stim_row_t dir_rows [DIR_ROWS] = '{
        '{ROW_SAMPLE, 32'h0000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0, 1'b1, 32'h7FFF_FFFF},
        '{ROW_SAMPLE, 32'h0000_0000, 32'h8000_0000, 32'h0, 32'h0, 1'b1, 32'h8000_0000},
        '{ROW_SAMPLE, 32'h0000_0005, 32'h0000_0064, 32'h0, 32'h0, 1'b1, 32'h8000_0000},
        '{ROW_SAMPLE, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0, 32'h0, 1'b0, 32'h0},
        '{ROW_LIMITS, 32'h0, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 32'h0},
        '{ROW_SAMPLE, 32'h0000_0000, 32'h1234_5678, 32'h0, 32'h0, 1'b0, 32'h0},
        '{ROW_SAMPLE, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h0, 32'h0, 1'b0, 32'h0},
        '{ROW_LIMITS, 32'h0, 32'h0, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 32'h0},
        '{ROW_SAMPLE, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0, 32'h0, 1'b0, 32'h0},
        '{ROW_SAMPLE, 32'h0000_0000, 32'h0000_0000, 32'h0, 32'h0, 1'b0, 32'h0},
        '{ROW_LIMITS, 32'h0, 32'h0, 32'h0001_0000, 32'hFFFF_0000, 1'b0, 32'h0},
        '{ROW_SAMPLE, 32'h0000_000A, 32'h0010_0000, 32'h0, 32'h0, 1'b0, 32'h0},
        '{ROW_SAMPLE, 32'h0000_000B, 32'h8000_0000, 32'h0, 32'h0, 1'b0, 32'h0},
        '{ROW_SAMPLE, 32'h0000_000B, 32'h7FFF_FFFF, 32'h0, 32'h0, 1'b0, 32'h0},
        '{ROW_SAMPLE, 32'h0000_000C, 32'h0000_0000, 32'h0, 32'h0, 1'b0, 32'h0},
        '{ROW_LIMITS, 32'h0, 32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 32'h0},
        '{ROW_SAMPLE, 32'h0000_1000, 32'h0000_0000, 32'h0, 32'h0, 1'b0, 32'h0},
        '{ROW_SAMPLE, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0, 32'h0, 1'b0, 32'h0},
        '{ROW_SAMPLE, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0, 32'h0, 1'b0, 32'h0},
        '{ROW_LIMITS, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'h0000_0001, 1'b0, 32'h0},
        '{ROW_SAMPLE, 32'h0000_0003, 32'h0000_0000, 32'h0, 32'h0, 1'b0, 32'h0},
        '{ROW_SAMPLE, 32'h0000_0004, 32'h0000_0005, 32'h0, 32'h0, 1'b0, 32'h0}
    };

    // DUT ports; every input starts at a known value.
    logic       clk;
    logic       rst_n         = 1'b0;
    logic       cfg_wr_en     = 1'b0;
    cfg_index_t cfg_index     = CFG_RISING_LIMIT;
    data_word_t cfg_data      = '0;
    logic       in_valid      = 1'b0;
    logic       in_stall;
    time_word_t sample_time   = '0;
    data_word_t sample_value  = '0;
    logic       out_valid;
    logic       out_stall     = 1'b0;
    data_word_t limited_value;

    // Predictor state: limits, anchor point and last evaluation.
    data_word_t rise_lim, fall_lim;
    time_word_t anc_t, last_t;
    data_word_t anc_v, last_v;

    data_word_t expected_limited [$];
    int         err_count      = 0;
    int         cycle_count    = 0;
    int         send_idle_pct  = 0;
    int         recv_stall_pct = 0;
    bit         hold_request   = 1'b0;
    int         hold_left      = 0;

    // Random stimulus cursor: time walks forward, value drifts by gen_span.
    time_word_t  gen_t;
    data_word_t  gen_v;
    int unsigned gen_span;

    timestamped_slew_rate_limiter dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .sample_time   (sample_time),
        .sample_value  (sample_value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .limited_value (limited_value)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Project the anchor along a limit: clamp the product, then saturate.
    function automatic data_word_t project_from_anchor(data_word_t lim, longint dt);
        longint prod;
        longint sum;
        prod = longint'(lim) * dt;
        if (prod > PROD_CAP)
            prod = PROD_CAP;
        if (prod < -PROD_CAP)
            prod = -PROD_CAP;
        sum = prod + longint'(anc_v);
        if (sum > DATA_MAX)
            return data_word_t'(DATA_MAX[31:0]);
        if (sum < DATA_MIN)
            return data_word_t'(DATA_MIN[31:0]);
        return data_word_t'(sum[31:0]);
    endfunction

    // Advance the predictor by one word and return the limited value.
    function automatic data_word_t predict_limited(time_word_t t, data_word_t x);
        longint     dt;
        longint     diff;
        bit         over_rise;
        bit         under_fall;
        data_word_t y;
        // Commit the last evaluation as anchor once time moves past it.
        if (t > last_t)
        begin
            anc_t = last_t;
            anc_v = last_v;
        end
        dt = longint'({32'd0, t}) - longint'({32'd0, anc_t});
        if (dt > 0)
        begin
            diff       = longint'(x) - longint'(anc_v);
            over_rise  = diff > longint'(rise_lim) * dt;
            under_fall = diff < longint'(fall_lim) * dt;
        end
        else
        begin
            // Time not after the anchor: the rate counts as zero.
            over_rise  = rise_lim < 0;
            under_fall = fall_lim > 0;
        end
        // Rising test wins when both trip, crossed limits included.
        if (over_rise)
            y = project_from_anchor(rise_lim, dt);
        else if (under_fall)
            y = project_from_anchor(fall_lim, dt);
        else
            y = x;
        last_t = t;
        last_v = y;
        return y;
    endfunction

    task automatic report_mismatch(string what, data_word_t got, data_word_t want);
        $display("[%0t] %s: got %h, want %h", $realtime, what, got, want);
        err_count++;
    endtask

    // Offer one word after a random gap; record its expectation at the
    // negedge before the accepting edge, then return on that edge.
    task automatic drive_word(time_word_t t, data_word_t v, logic fixed,
                              data_word_t lit);
        data_word_t pred;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        sample_time  <= t;
        sample_value <= v;
        forever
        begin
            @(negedge clk);
            if (!in_stall)
                break;
            @(posedge clk);
        end
        pred = predict_limited(t, v);
        expected_limited.push_back(fixed ? lit : pred);
        @(posedge clk);
    endtask

    // Drop valid and hold until every expected word is out, plus a tail.
    task automatic wait_idle();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_limited.size() != 0);
        repeat (IDLE_TAIL) @(posedge clk);
    endtask

    // Write both limits back to back; call only with the block idle.
    task automatic set_limits(data_word_t rise, data_word_t fall);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_RISING_LIMIT;
        cfg_data  <= rise;
        @(posedge clk);
        cfg_index <= CFG_FALLING_LIMIT;
        cfg_data  <= fall;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        rise_lim = rise;
        fall_lim = fall;
    endtask

    // Limits per phase: typical, both extremes, zero, crossed, full random.
    task automatic pick_limits(int phase, output data_word_t rise,
                               output data_word_t fall);
        case (phase % 8)
            0:
            begin
                rise = $urandom_range(1, 1 << 20);
                fall = 0 - $urandom_range(1, 1 << 20);
            end
            1:
            begin
                rise = 32'h7FFF_FFFF;
                fall = 32'h8000_0000;
            end
            2:
            begin
                rise = 32'h8000_0000;
                fall = 32'h7FFF_FFFF;
            end
            3:
            begin
                rise = '0;
                fall = '0;
            end
            4:
            begin
                rise = $urandom;
                fall = $urandom;
            end
            5:
            begin
                rise = $urandom_range(0, 1 << 16);
                fall = 0 - $urandom_range(0, 1 << 16);
            end
            6:
            begin
                rise = 0 - $urandom_range(1, 1 << 18);
                fall = $urandom_range(1, 1 << 18);
            end
            default:
            begin
                rise = $urandom_range(0, 1 << 24);
                fall = $urandom;
            end
        endcase
    endtask

    // Mostly a forward-moving ramp; some repeats, steps back, jumps and noise.
    task automatic gen_sample(output time_word_t t, output data_word_t v);
        int unsigned r;
        r = $urandom_range(99);
        if (r < 60)
            gen_t = gen_t + $urandom_range(1, 8);
        else if (r < 75)
            gen_t = gen_t;
        else if (r < 85)
            gen_t = gen_t - $urandom_range(1, 20);
        else if (r < 92)
            gen_t = gen_t + $urandom_range(9, 5000);
        else
            gen_t = $urandom;
        r = $urandom_range(99);
        if (r < 70)
            gen_v = gen_v + $urandom_range(0, 2 * gen_span) - gen_span;
        else if (r < 85)
            gen_v = $urandom;
        else if (r < 92)
            gen_v = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        else
            gen_v = $urandom_range(0, 64) - 32;
        t = gen_t;
        v = gen_v;
    endtask

    // Receiver: random stall, or a long hold-off counted here on request.
    always @(posedge clk)
    begin
        if (hold_request)
        begin
            hold_left    = HOLD_LEN;
            hold_request = 1'b0;
        end
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left = hold_left - 1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Checker: sample mid-cycle what the next rising edge will accept.
    always @(negedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_limited.size() == 0)
                report_mismatch("limited_value with no word pending", limited_value, 'x);
            else
            begin
                if (limited_value !== expected_limited[0])
                    report_mismatch("limited_value", limited_value, expected_limited[0]);
                void'(expected_limited.pop_front());
            end
        end
    end

    // Watchdog: give up well past the slowest correct run.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timestamped_slew_rate_limiter_tb: done, errors");
        $finish;
    end

    initial
    begin
        time_word_t t;
        data_word_t v;
        data_word_t rise;
        data_word_t fall;
        int         phase;
        int         k;

        // Predictor comes out of reset like the block.
        rise_lim = '0;
        fall_lim = '0;
        anc_t    = '0;
        anc_v    = '0;
        last_t   = '0;
        last_v   = '0;
        gen_t    = '0;
        gen_v    = '0;
        gen_span = 1 << 16;

        // Hold reset, then release it on a rising edge.
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table: extremes, time steps back and repeats, crossed
        // limits, saturation both ways.
        for (k = 0; k < DIR_ROWS; k++)
        begin
            if (dir_rows[k].kind == ROW_LIMITS)
            begin
                wait_idle();
                set_limits(dir_rows[k].rise, dir_rows[k].fall);
            end
            else
                drive_word(dir_rows[k].t, dir_rows[k].v, dir_rows[k].fixed,
                           dir_rows[k].lit);
        end

        // Random phases: new limits each time, idling cycles through
        // none / sender 81% / receiver 81% / both 13%.
        for (phase = 0; phase < PHASES; phase++)
        begin
            wait_idle();
            pick_limits(phase, rise, fall);
            set_limits(rise, fall);
            gen_span = 1 << $urandom_range(12, 24);
            case (phase % 4)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 81;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 81;
                end
                default:
                begin
                    send_idle_pct  = 13;
                    recv_stall_pct = 13;
                end
            endcase
            // Fill the block against a long hold-off while words keep coming.
            if (phase == 4)
                hold_request = 1'b1;
            for (k = 0; k < PHASE_WORDS; k++)
            begin
                // Pause the sender until every pending word has come out.
                if (phase == 6 && k == PHASE_WORDS / 2)
                begin
                    in_valid <= 1'b0;
                    do
                        @(posedge clk);
                    while (expected_limited.size() != 0);
                end
                gen_sample(t, v);
                drive_word(t, v, 1'b0, '0);
            end
        end

        // Drain, then watch a few more cycles for stray words.
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_limited.size() != 0);
        repeat (IDLE_TAIL * 2) @(posedge clk);

        if (err_count == 0 && expected_limited.size() == 0)
            $display("timestamped_slew_rate_limiter_tb: done, clean");
        else
            $display("timestamped_slew_rate_limiter_tb: done, errors");
        $finish;
    end

endmodule
